@@ rtl/ctp_pkg.sv @@
`timescale 1ns / 1ps

package ctp_pkg;

  // Field widths of the result item and of one code unit on the input.
  localparam int COLOR_W = 16;
  localparam int CHAR_W  = 16;

  // Default code unit width inside the block.
  localparam int CHAR_BITS_DEF = 16;

  // Default depth of the queue between the front and the back part.
  localparam int QUEUE_DEPTH_DEF = 4;

  // Characters that the parser reacts to.
  localparam logic [CHAR_W-1:0] CH_LT  = 16'h003C;
  localparam logic [CHAR_W-1:0] CH_GT  = 16'h003E;
  localparam logic [CHAR_W-1:0] CH_BSL = 16'h005C;

  // Reset value of both color registers ('X').
  localparam logic [COLOR_W-1:0] COLOR_RESET = 16'h0058;

  // Configuration port: two registers at byte addresses 0 and 4.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_BG = 1'b0;
  localparam logic REG_FG = 1'b1;

  // Layout of a queued item: class flags in the low bits, code unit above.
  localparam int FLAG_LT   = 0;
  localparam int FLAG_GT   = 1;
  localparam int FLAG_BSL  = 2;
  localparam int FLAG_LAST = 3;
  localparam int FLAG_W    = 4;

  // Register write as seen by the parser.
  typedef struct packed {
    logic               bg_we;
    logic               fg_we;
    logic [COLOR_W-1:0] data;
  } cfg_wr_t;

endpackage

@@ rtl/ctp_front.sv @@
`timescale 1ns / 1ps

module ctp_front import ctp_pkg::*; #(
  parameter int CHAR_BITS = CHAR_BITS_DEF
) (
  input  logic                           in_valid,
  input  logic [CHAR_W-1:0]              in_text_char,
  input  logic                           in_end_of_text,
  output logic                           push_valid,
  output logic [FLAG_W+CHAR_W-1:0]       push_data_full
);

  localparam int CW = (CHAR_BITS < CHAR_W) ? CHAR_BITS : CHAR_W;

  logic [CW-1:0] ch;

  // The code unit is cut to the width the parser works at.
  assign ch = in_text_char[CW-1:0];

  // Classify the item once here, so the back part only looks at flags.
  always_comb begin
    push_data_full = '0;
    push_data_full[FLAG_W +: CW]  = ch;
    push_data_full[FLAG_LT]       = (ch == CW'(CH_LT));
    push_data_full[FLAG_GT]       = (ch == CW'(CH_GT));
    push_data_full[FLAG_BSL]      = (ch == CW'(CH_BSL));
    push_data_full[FLAG_LAST]     = in_end_of_text;
  end

  assign push_valid = in_valid;

endmodule

@@ rtl/ctp_queue.sv @@
`timescale 1ns / 1ps

module ctp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data,
  input  logic             pop
);

  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push_fire;
  logic             pop_fire;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop && pop_valid;

  // Pointers wrap at the depth, which need not be a power of two.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    count_nxt = count_r + CNT_W'(push_fire) - CNT_W'(pop_fire);
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slot_r[wr_ptr_r] <= push_data;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/ctp_back.sv @@
`timescale 1ns / 1ps

module ctp_back import ctp_pkg::*; #(
  parameter int CHAR_BITS = CHAR_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Classified items from the queue
  input  logic                   q_valid,
  input  logic [FLAG_W+((CHAR_BITS < CHAR_W) ? CHAR_BITS : CHAR_W)-1:0] q_data,
  output logic                   q_pop,
  // Color registers
  input  cfg_wr_t                cfg_wr,
  input  logic [COLOR_W-1:0]     init_bg,
  input  logic [COLOR_W-1:0]     init_fg,
  // Result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [COLOR_W-1:0]     out_back_color,
  output logic [COLOR_W-1:0]     out_fore_color,
  output logic [CHAR_W-1:0]      out_glyph,
  output logic                   out_glyph_present,
  output logic                   out_last_of_text
);

  localparam int CW = (CHAR_BITS < CHAR_W) ? CHAR_BITS : CHAR_W;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SET,   // color tag: load colors, drop four units
    OP_ESC,   // escaped tag opener: send '<' on the backslash's colors
    OP_REL,   // send the held backslash before the next character
    OP_EMIT,  // send the head character, or hold it if it is a backslash
    OP_END    // end of string: release the held backslash or send a bare end
  } op_t;

  // Window of pending units
  logic [CW-1:0]      w_ch_r [4];
  logic [CW-1:0]      w_ch_nxt [4];
  logic [3:0]         w_lt_r, w_lt_nxt;
  logic [3:0]         w_gt_r, w_gt_nxt;
  logic [3:0]         w_bsl_r, w_bsl_nxt;
  logic [2:0]         fill_r, fill_nxt;
  logic               drain_r, drain_nxt;

  // Parser state
  logic [COLOR_W-1:0] cur_bg_r, cur_bg_nxt;
  logic [COLOR_W-1:0] cur_fg_r, cur_fg_nxt;
  logic               prev_valid_r, prev_valid_nxt;
  logic               prev_bsl_r, prev_bsl_nxt;
  logic [COLOR_W-1:0] held_bg_r, held_bg_nxt;
  logic [COLOR_W-1:0] held_fg_r, held_fg_nxt;
  logic               held_valid_r, held_valid_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0] out_bg_r, out_bg_nxt;
  logic [COLOR_W-1:0] out_fg_r, out_fg_nxt;
  logic [CHAR_W-1:0]  out_glyph_r, out_glyph_nxt;
  logic               out_present_r, out_present_nxt;
  logic               out_last_r, out_last_nxt;

  // Window as seen this cycle, with the incoming item appended
  logic [CW-1:0]      v_ch [4];
  logic [3:0]         v_lt, v_gt, v_bsl;
  logic [2:0]         vfill;

  logic               out_ready;
  logic               take;
  logic               q_last;
  logic               full4;
  logic               tag_shape;
  logic               escape;
  logic               needs_put;
  logic               final_res;
  logic               go;
  logic               end_step;
  logic               idle;
  op_t                op;

  assign out_ready = !out_valid_r || !out_stall;
  assign take      = q_valid && !drain_r && (fill_r != 3'd4);
  assign q_pop     = take;
  assign q_last    = q_data[FLAG_LAST];
  assign vfill     = fill_r + 3'(take);
  assign idle      = !prev_valid_r && (fill_r == 3'd0) && !held_valid_r;

  // Append the incoming item behind the stored units.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (take && (fill_r == 3'(i))) begin
        v_ch[i]  = q_data[FLAG_W +: CW];
        v_lt[i]  = q_data[FLAG_LT];
        v_gt[i]  = q_data[FLAG_GT];
        v_bsl[i] = q_data[FLAG_BSL];
      end else begin
        v_ch[i]  = w_ch_r[i];
        v_lt[i]  = w_lt_r[i];
        v_gt[i]  = w_gt_r[i];
        v_bsl[i] = w_bsl_r[i];
      end
    end
  end

  // Decide what the head of the window does this cycle.
  assign full4     = (vfill == 3'd4);
  assign tag_shape = full4 && v_lt[0] && v_gt[3];
  assign escape    = tag_shape && prev_valid_r && prev_bsl_r;

  always_comb begin
    priority if (full4) begin
      if (tag_shape) begin
        op = escape ? OP_ESC : OP_SET;
      end else begin
        op = held_valid_r ? OP_REL : OP_EMIT;
      end
    end else if (drain_r) begin
      if (vfill == 3'd0) begin
        op = OP_END;
      end else begin
        op = held_valid_r ? OP_REL : OP_EMIT;
      end
    end else begin
      op = OP_NONE;
    end
  end

  always_comb begin
    unique case (op)
      OP_ESC, OP_REL, OP_END: needs_put = 1'b1;
      OP_EMIT:                needs_put = !v_bsl[0];
      OP_NONE, OP_SET:        needs_put = 1'b0;
      default:                needs_put = 1'b0;
    endcase
  end

  // The last result of a string is either the end release or the last
  // plain character left in the window while draining.
  assign final_res = (op == OP_END) ||
                     ((op == OP_EMIT) && drain_r && (vfill == 3'd1) && !v_bsl[0]);
  assign go        = (op != OP_NONE) && (!needs_put || out_ready);
  assign end_step  = go && final_res;

  // Next state of the window, the parser and the output register.
  always_comb begin
    w_ch_nxt        = v_ch;
    w_lt_nxt        = v_lt;
    w_gt_nxt        = v_gt;
    w_bsl_nxt       = v_bsl;
    fill_nxt        = vfill;
    drain_nxt       = drain_r;
    cur_bg_nxt      = cur_bg_r;
    cur_fg_nxt      = cur_fg_r;
    prev_valid_nxt  = prev_valid_r;
    prev_bsl_nxt    = prev_bsl_r;
    held_bg_nxt     = held_bg_r;
    held_fg_nxt     = held_fg_r;
    held_valid_nxt  = held_valid_r;

    out_valid_nxt   = out_valid_r && out_stall;
    out_bg_nxt      = out_bg_r;
    out_fg_nxt      = out_fg_r;
    out_glyph_nxt   = out_glyph_r;
    out_present_nxt = out_present_r;
    out_last_nxt    = out_last_r;

    if (go) begin
      unique case (op)
        OP_SET: begin
          cur_bg_nxt     = COLOR_W'(v_ch[1]);
          cur_fg_nxt     = COLOR_W'(v_ch[2]);
          fill_nxt       = 3'd0;
          prev_valid_nxt = 1'b1;
          prev_bsl_nxt   = v_bsl[3];
        end
        OP_ESC: begin
          out_bg_nxt      = held_valid_r ? held_bg_r : cur_bg_r;
          out_fg_nxt      = held_valid_r ? held_fg_r : cur_fg_r;
          out_glyph_nxt   = CH_LT;
          out_present_nxt = 1'b1;
          held_valid_nxt  = 1'b0;
        end
        OP_REL: begin
          out_bg_nxt      = held_bg_r;
          out_fg_nxt      = held_fg_r;
          out_glyph_nxt   = CH_BSL;
          out_present_nxt = 1'b1;
          held_valid_nxt  = 1'b0;
        end
        OP_EMIT: begin
          if (v_bsl[0]) begin
            held_bg_nxt    = cur_bg_r;
            held_fg_nxt    = cur_fg_r;
            held_valid_nxt = 1'b1;
          end else begin
            out_bg_nxt      = cur_bg_r;
            out_fg_nxt      = cur_fg_r;
            out_glyph_nxt   = CHAR_W'(v_ch[0]);
            out_present_nxt = 1'b1;
          end
        end
        OP_END: begin
          out_bg_nxt      = held_valid_r ? held_bg_r : cur_bg_r;
          out_fg_nxt      = held_valid_r ? held_fg_r : cur_fg_r;
          out_glyph_nxt   = held_valid_r ? CH_BSL : '0;
          out_present_nxt = held_valid_r;
          held_valid_nxt  = 1'b0;
        end
        OP_NONE: begin
        end
        default: begin
        end
      endcase

      // Single-unit consume: shift the window down by one.
      if ((op == OP_ESC) || (op == OP_EMIT)) begin
        for (int i = 0; i < 3; i++) begin
          w_ch_nxt[i] = v_ch[i+1];
        end
        w_lt_nxt       = {v_lt[3], v_lt[3:1]};
        w_gt_nxt       = {v_gt[3], v_gt[3:1]};
        w_bsl_nxt      = {v_bsl[3], v_bsl[3:1]};
        fill_nxt       = vfill - 3'd1;
        prev_valid_nxt = 1'b1;
        prev_bsl_nxt   = v_bsl[0];
      end

      if (needs_put) begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = final_res;
      end
    end

    // A finished string puts the colors back and forgets the last unit.
    if (end_step) begin
      cur_bg_nxt     = init_bg;
      cur_fg_nxt     = init_fg;
      prev_valid_nxt = 1'b0;
      drain_nxt      = 1'b0;
    end

    if (take && q_last) begin
      drain_nxt = 1'b1;
    end

    // Between strings a register write also sets the live color.
    if (idle) begin
      if (cfg_wr.bg_we) begin
        cur_bg_nxt = cfg_wr.data;
      end
      if (cfg_wr.fg_we) begin
        cur_fg_nxt = cfg_wr.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    w_ch_r        <= w_ch_nxt;
    w_lt_r        <= w_lt_nxt;
    w_gt_r        <= w_gt_nxt;
    w_bsl_r       <= w_bsl_nxt;
    held_bg_r     <= held_bg_nxt;
    held_fg_r     <= held_fg_nxt;
    out_bg_r      <= out_bg_nxt;
    out_fg_r      <= out_fg_nxt;
    out_glyph_r   <= out_glyph_nxt;
    out_present_r <= out_present_nxt;
    out_last_r    <= out_last_nxt;
    if (!rst_n) begin
      fill_r       <= 3'd0;
      drain_r      <= 1'b0;
      cur_bg_r     <= COLOR_RESET;
      cur_fg_r     <= COLOR_RESET;
      prev_valid_r <= 1'b0;
      prev_bsl_r   <= 1'b0;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      fill_r       <= fill_nxt;
      drain_r      <= drain_nxt;
      cur_bg_r     <= cur_bg_nxt;
      cur_fg_r     <= cur_fg_nxt;
      prev_valid_r <= prev_valid_nxt;
      prev_bsl_r   <= prev_bsl_nxt;
      held_valid_r <= held_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_back_color    = out_bg_r;
  assign out_fore_color    = out_fg_r;
  assign out_glyph         = out_glyph_r;
  assign out_glyph_present = out_present_r;
  assign out_last_of_text  = out_last_r;

endmodule

@@ rtl/color_tag_markup_parser.sv @@
`timescale 1ns / 1ps

// Color tag parser: takes one text code unit per item and returns
// (background, foreground, glyph) results, one per cycle at most. A plain
// character is passed on when the result side keeps up, and a complete tag
// is consumed without a result; a backslash is held back and released ahead
// of the character that follows it. The end of a string flushes the final
// item and up to three units still pending in the window, plus the held
// backslash. Each of those four units may first have to release a held
// backslash, and the end marker or the held backslash may need a result of
// its own, and no new string starts in the cycle that delivers the last
// result. The single output register passes one result per cycle while the
// receiver does not stall it; a small queue in front of the parser lets
// input flow continue while the parser flushes or releases. Color registers
// sit at byte addresses 0 and 4; writing one between strings also changes
// the colors in force right away. Reset clears all control state at once,
// no clearing pass is needed.

module color_tag_markup_parser import ctp_pkg::*; #(
  parameter int CHAR_BITS   = CHAR_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CHAR_W-1:0]     in_text_char,
  input  logic                  in_end_of_text,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COLOR_W-1:0]    out_back_color,
  output logic [COLOR_W-1:0]    out_fore_color,
  output logic [CHAR_W-1:0]     out_glyph,
  output logic                  out_glyph_present,
  output logic                  out_last_of_text,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CW     = (CHAR_BITS < CHAR_W) ? CHAR_BITS : CHAR_W;
  localparam int ITEM_W = FLAG_W + CW;

  logic [COLOR_W-1:0]       init_bg_r, init_bg_nxt;
  logic [COLOR_W-1:0]       init_fg_r, init_fg_nxt;
  logic                     cfg_write;
  logic                     reg_sel;
  cfg_wr_t                  cfg_wr;

  logic                     push_valid;
  logic [FLAG_W+CHAR_W-1:0] push_data_full;
  logic                     push_ready;
  logic                     pop_valid;
  logic [ITEM_W-1:0]        pop_data;
  logic                     pop;

  // Register file for the two start colors.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = paddr[CFG_ADDR_W-1];

  always_comb begin
    cfg_wr.bg_we = cfg_write && (reg_sel == REG_BG);
    cfg_wr.fg_we = cfg_write && (reg_sel == REG_FG);
    cfg_wr.data  = pwdata[COLOR_W-1:0];
    init_bg_nxt  = cfg_wr.bg_we ? cfg_wr.data : init_bg_r;
    init_fg_nxt  = cfg_wr.fg_we ? cfg_wr.data : init_fg_r;
  end

  always_comb begin
    unique case (reg_sel)
      REG_BG:  prdata = CFG_DATA_W'(init_bg_r);
      REG_FG:  prdata = CFG_DATA_W'(init_fg_r);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_bg_r <= COLOR_RESET;
      init_fg_r <= COLOR_RESET;
    end else begin
      init_bg_r <= init_bg_nxt;
      init_fg_r <= init_fg_nxt;
    end
  end

  // Front part: classify each item on its way into the queue.
  ctp_front #(
    .CHAR_BITS (CHAR_BITS)
  ) u_front (
    .in_valid       (in_valid),
    .in_text_char   (in_text_char),
    .in_end_of_text (in_end_of_text),
    .push_valid     (push_valid),
    .push_data_full (push_data_full)
  );

  assign in_stall = !push_ready;

  ctp_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data_full[ITEM_W-1:0]),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop        (pop)
  );

  // Back part: window, tag decisions and the result register.
  ctp_back #(
    .CHAR_BITS (CHAR_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (pop_valid),
    .q_data            (pop_data),
    .q_pop             (pop),
    .cfg_wr            (cfg_wr),
    .init_bg           (init_bg_r),
    .init_fg           (init_fg_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_back_color    (out_back_color),
    .out_fore_color    (out_fore_color),
    .out_glyph         (out_glyph),
    .out_glyph_present (out_glyph_present),
    .out_last_of_text  (out_last_of_text)
  );

endmodule

@@ verif/color_tag_markup_parser_tb.sv @@
`timescale 1ns / 1ps

module color_tag_markup_parser_tb;
  import ctp_pkg::*;

  // One attributed character as it leaves the parser.
  typedef struct packed {
    logic [COLOR_W-1:0] back;
    logic [COLOR_W-1:0] fore;
    logic [CHAR_W-1:0]  glyph;
    logic               present;
    logic               last;
  } attr_char_t;

  // One input item, with a typed-in result where it is obvious.
  typedef struct {
    logic [CHAR_W-1:0] ch;
    bit                eot;
    bit                typed;
    attr_char_t        want;
  } row_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CHAR_W-1:0]     in_text_char = '0;
  logic                  in_end_of_text = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [COLOR_W-1:0]    out_back_color;
  logic [COLOR_W-1:0]    out_fore_color;
  logic [CHAR_W-1:0]     out_glyph;
  logic                  out_glyph_present;
  logic                  out_last_of_text;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  color_tag_markup_parser u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_text_char      (in_text_char),
    .in_end_of_text    (in_end_of_text),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_back_color    (out_back_color),
    .out_fore_color    (out_fore_color),
    .out_glyph         (out_glyph),
    .out_glyph_present (out_glyph_present),
    .out_last_of_text  (out_last_of_text),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Parser state mirrored by the testbench.
  logic [CHAR_W-1:0]  win_units [4];
  int                 win_fill = 0;
  logic [COLOR_W-1:0] init_bg = COLOR_RESET;
  logic [COLOR_W-1:0] init_fg = COLOR_RESET;
  logic [COLOR_W-1:0] cur_bg = COLOR_RESET;
  logic [COLOR_W-1:0] cur_fg = COLOR_RESET;
  logic [CHAR_W-1:0]  prev_char = '0;
  bit                 prev_ok = 1'b0;
  attr_char_t         held_bsl = '0;
  bit                 held_ok = 1'b0;

  // Attributed characters still to come out of the block, oldest first.
  attr_char_t char_q[$];

  int errors = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  function automatic void push_char(logic [COLOR_W-1:0] b, logic [COLOR_W-1:0] f,
                                    logic [CHAR_W-1:0] g);
    char_q.insert(char_q.size(), '{b, f, g, 1'b1, 1'b0});
  endfunction

  function automatic void release_held();
    if (held_ok) begin
      push_char(held_bsl.back, held_bsl.fore, held_bsl.glyph);
      held_ok = 1'b0;
    end
  endfunction

  function automatic void consume_units(int k);
    prev_char = win_units[k-1];
    prev_ok = 1'b1;
    for (int i = 0; i + k < win_fill; i++) win_units[i] = win_units[i+k];
    win_fill -= k;
  endfunction

  // Resolve the unit at the head of the window.
  function automatic void process_head();
    logic [CHAR_W-1:0] c;
    c = win_units[0];
    if (c == CH_LT && win_fill >= 4 && win_units[3] == CH_GT) begin
      if (prev_ok && prev_char == CH_BSL) begin
        // Escaped tag: the backslash turns into a literal '<'.
        if (held_ok) begin
          push_char(held_bsl.back, held_bsl.fore, CH_LT);
          held_ok = 1'b0;
        end else begin
          push_char(cur_bg, cur_fg, CH_LT);
        end
        consume_units(1);
      end else begin
        cur_bg = win_units[1];
        cur_fg = win_units[2];
        consume_units(4);
      end
    end else begin
      // Plain text; a backslash waits one emission for a possible escape.
      release_held();
      if (c == CH_BSL) begin
        held_bsl = '{cur_bg, cur_fg, c, 1'b1, 1'b0};
        held_ok = 1'b1;
      end else begin
        push_char(cur_bg, cur_fg, c);
      end
      consume_units(1);
    end
  endfunction

  // Take one accepted item and queue the characters it releases.
  function automatic int predict_unit(logic [CHAR_W-1:0] ch, bit eot);
    int base;
    base = char_q.size();
    if (win_fill < 4) begin
      win_units[win_fill] = ch;
      win_fill++;
    end
    while (win_fill >= 4) process_head();
    if (eot) begin
      while (win_fill > 0) process_head();
      release_held();
      if (char_q.size() > base) begin
        char_q[char_q.size() - 1].last = 1'b1;
      end else begin
        char_q.insert(char_q.size(), '{cur_bg, cur_fg, '0, 1'b0, 1'b1});
      end
      cur_bg = init_bg;
      cur_fg = init_fg;
      prev_char = '0;
      prev_ok = 1'b0;
    end
    return char_q.size() - base;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $error("%s: expected %h, got %h", name, want, got);
    end
  endfunction

  // Code unit for tag contents: mostly random, sometimes a markup character.
  function automatic logic [CHAR_W-1:0] rand_unit();
    case ($urandom_range(9))
      0: return CH_LT;
      1: return CH_GT;
      2: return CH_BSL;
      default: return CHAR_W'($urandom);
    endcase
  endfunction

  // Write a color register between strings, then read it back.
  task automatic set_color_reg(logic reg_idx, logic [COLOR_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'({reg_idx, 2'b00});
    pwdata <= CFG_DATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_idx == REG_BG) begin
      init_bg = val;
      if (!prev_ok && win_fill == 0 && !held_ok) cur_bg = val;
    end else begin
      init_fg = val;
      if (!prev_ok && win_fill == 0 && !held_ok) cur_fg = val;
    end
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("prdata", CFG_DATA_W'(val), prdata);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offer one item from a falling edge and return at the falling edge after acceptance.
  task automatic send_item(row_t r);
    int n;
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_text_char <= r.ch;
    in_end_of_text <= r.eot;
    do @(posedge clk); while (in_stall);
    n = predict_unit(r.ch, r.eot);
    if (r.typed) begin
      repeat (n) void'(char_q.pop_back());
      char_q.insert(char_q.size(), r.want);
    end
    items_sent++;
    @(negedge clk);
  endtask

  // Build one string out of text, tags, escapes and broken markup, then send it.
  task automatic send_string();
    logic [CHAR_W-1:0] units[$];
    row_t r;
    int ntok;
    int cut;
    ntok = $urandom_range(1, 4);
    repeat (ntok) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          repeat ($urandom_range(1, 3)) units.insert(units.size(), CHAR_W'($urandom));
        end
        3, 4, 5: begin
          units.insert(units.size(), CH_LT);
          units.insert(units.size(), rand_unit());
          units.insert(units.size(), rand_unit());
          units.insert(units.size(), CH_GT);
        end
        6, 7: begin
          units.insert(units.size(), CH_BSL);
          units.insert(units.size(), CH_LT);
          units.insert(units.size(), rand_unit());
          units.insert(units.size(), rand_unit());
          units.insert(units.size(), CH_GT);
        end
        8: begin
          units.insert(units.size(), rand_unit());
        end
        default: begin
          units.insert(units.size(), CH_LT);
          repeat ($urandom_range(1, 3)) units.insert(units.size(), rand_unit());
        end
      endcase
    end
    // Now and then one to three units are cut off the end, which can end the string in the middle of a tag.
    if (units.size() > 1 && $urandom_range(6) == 0) begin
      cut = $urandom_range(1, 3);
      while (cut > 0 && units.size() > 1) begin
        void'(units.pop_back());
        cut--;
      end
    end
    foreach (units[i]) begin
      r.ch = units[i];
      r.eot = (i == units.size() - 1);
      r.typed = 1'b0;
      r.want = '0;
      send_item(r);
    end
  endtask

  // Stop offering items and wait until every expected character has come out.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (char_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Receiver: random stalls plus an occasional long hold-off.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 200;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (int'($urandom_range(99)) < recv_stall_pct);
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    attr_char_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (char_q.size() == 0) begin
        errors++;
        $error("unexpected result: glyph %h last %b", out_glyph, out_last_of_text);
      end else begin
        want = char_q.pop_front();
        check_field("back_color", want.back, out_back_color);
        check_field("fore_color", want.fore, out_fore_color);
        check_field("glyph", want.glyph, out_glyph);
        check_field("glyph_present", want.present, out_glyph_present);
        check_field("last_of_text", want.last, out_last_of_text);
      end
    end
  end

  // Directed strings.
  row_t directed_rows [26] = '{
    // Plain character with the reset colors.
    '{16'h0041, 1'b1, 1'b1, '{COLOR_RESET, COLOR_RESET, 16'h0041, 1'b1, 1'b1}},
    // Tag with extreme colors closing the string: only a bare end marker.
    '{CH_LT, 1'b0, 1'b0, '0},
    '{16'h0000, 1'b0, 1'b0, '0},
    '{16'hFFFF, 1'b0, 1'b0, '0},
    '{CH_GT, 1'b1, 1'b1, '{16'h0000, 16'hFFFF, 16'h0000, 1'b0, 1'b1}},
    // Extreme code units; colors are back at the register values.
    '{16'hFFFF, 1'b1, 1'b1, '{COLOR_RESET, COLOR_RESET, 16'hFFFF, 1'b1, 1'b1}},
    '{16'h0000, 1'b1, 1'b1, '{COLOR_RESET, COLOR_RESET, 16'h0000, 1'b1, 1'b1}},
    // A lone backslash is held and then released by the end of the string.
    '{CH_BSL, 1'b1, 1'b1, '{COLOR_RESET, COLOR_RESET, CH_BSL, 1'b1, 1'b1}},
    // Tag on the first unit, right after a string that ended in a backslash.
    '{CH_LT, 1'b0, 1'b0, '0},
    '{16'h0012, 1'b0, 1'b0, '0},
    '{16'h0034, 1'b0, 1'b0, '0},
    '{CH_GT, 1'b0, 1'b0, '0},
    '{16'h0041, 1'b1, 1'b0, '0},
    // Escaped tag: the rest of it comes out as text.
    '{CH_BSL, 1'b0, 1'b0, '0},
    '{CH_LT, 1'b0, 1'b0, '0},
    '{16'h0001, 1'b0, 1'b0, '0},
    '{16'h0002, 1'b0, 1'b0, '0},
    '{CH_GT, 1'b0, 1'b0, '0},
    '{16'h0042, 1'b1, 1'b0, '0},
    // Tag cut short by the end of the string.
    '{CH_LT, 1'b0, 1'b0, '0},
    '{16'h0043, 1'b1, 1'b0, '0},
    // Invalid tag, scanned again as plain text.
    '{CH_LT, 1'b0, 1'b0, '0},
    '{16'h0044, 1'b0, 1'b0, '0},
    '{16'h0045, 1'b0, 1'b0, '0},
    '{16'h0046, 1'b0, 1'b0, '0},
    '{CH_GT, 1'b1, 1'b0, '0}
  };

  initial begin : stimulus
    logic [COLOR_W-1:0] bg;
    logic [COLOR_W-1:0] fg;
    int stop_at;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) send_item(directed_rows[i]);
    wait_drain();

    // Random phases, each with its own color setting and idling pattern.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          bg = 16'h0000;
          fg = 16'hFFFF;
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          bg = 16'hFFFF;
          fg = 16'h0000;
          send_idle_pct = 65;
          recv_stall_pct = 0;
        end
        2: begin
          bg = COLOR_W'($urandom);
          fg = COLOR_W'($urandom);
          send_idle_pct = 0;
          recv_stall_pct = 65;
        end
        default: begin
          bg = COLOR_RESET;
          fg = COLOR_W'($urandom);
          send_idle_pct = 16;
          recv_stall_pct = 16;
        end
      endcase
      set_color_reg(REG_BG, bg);
      set_color_reg(REG_FG, fg);
      // Long receiver hold-off while items keep coming, to fill the block.
      if (ph == 0) hold_req++;
      stop_at = items_sent + 100;
      while (items_sent < stop_at) send_string();
      wait_drain();
    end

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ctp_pkg.sv
rtl/ctp_front.sv
rtl/ctp_queue.sv
rtl/ctp_back.sv
rtl/color_tag_markup_parser.sv
verif/color_tag_markup_parser_tb.sv
